[hw/rtl/kci_pkg.sv]
// Shared types, constants and codes for the keyframe curve interpolator.
package kci_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int FRAC_BITS = 16;

  localparam int KEY_AW  = $clog2(MAX_KEYS);
  localparam int CNT_W   = KEY_AW + 1;
  localparam int DATA_W  = 32;
  localparam int DIFF_W  = DATA_W + 1;
  localparam int WGT_W   = FRAC_BITS + 1;
  localparam int SQ_W    = 2 * WGT_W;
  localparam int CUBE_W  = FRAC_BITS + 3;
  localparam int SM_W    = WGT_W + CUBE_W;
  localparam int PROD_W  = DIFF_W + WGT_W + 1;

  localparam logic [CUBE_W-1:0] THREE_ONE = CUBE_W'(3) << FRAC_BITS;

  localparam logic [0:0] CMD_ADD    = 1'b0;
  localparam logic [0:0] CMD_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_LINEAR   = 2'd0;
  localparam logic [1:0] MODE_SMOOTH   = 2'd1;
  localparam logic [1:0] MODE_STEP     = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] STAT_SAMPLED  = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_INSERTED = 3'd2;
  localparam logic [2:0] STAT_UPDATED  = 3'd3;
  localparam logic [2:0] STAT_DROPPED  = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] time_pt;
    logic [DATA_W-1:0] level;
    logic [1:0]        mode;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CMP,
    S_A_PLACE,
    S_SH_RD,
    S_SH_WR,
    S_S_FIRST,
    S_S_LAST,
    S_S_SCAN,
    S_DIV,
    S_SM1,
    S_SM2,
    S_MIX,
    S_SUM,
    S_DONE
  } state_e;

endpackage

[hw/rtl/kci_ram.sv]
// Generic simple dual-port RAM with registered read.
module kci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/kci_div.sv]
// Serial restoring divider that forms the interval weight, one bit a cycle.
module kci_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kci_pkg::DIFF_W-1:0]    num_i,
  input  logic [kci_pkg::DIFF_W-1:0]    den_i,
  output logic                          done_o,
  output logic [kci_pkg::WGT_W-1:0]     quo_o
);
  import kci_pkg::*;

  localparam int STEP_W = $clog2(WGT_W);

  logic [DIFF_W:0]    rem_q, rem_d;
  logic [DIFF_W-1:0]  den_q, den_d;
  logic [WGT_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               ge;
  logic [DIFF_W:0]    rem_sub;

  always_comb begin
    ge      = rem_q >= {1'b0, den_q};
    rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quo_d  = '0;
      step_d = STEP_W'(WGT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = {rem_sub[DIFF_W-1:0], 1'b0};
      quo_d = {quo_q[WGT_W-2:0], ge};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hw/rtl/keyframe_curve_interpolator_top.sv]
// Keyframe curve interpolator: sorted key table in RAM, search, insert and blend.
//
// One request at a time. Keys live in a single 64-entry RAM with registered
// read, sorted by time. An add walks the table from the start over the keys
// below the new time, then updates an equal key in place or shifts the keys
// above it up by one. A sample reads the first and last keys, scans forward
// one key a cycle to the interval, then, unless the lower key is a step key,
// runs a 17-step serial divider for the weight, the SM1 and SM2 smoothstep
// states in smooth mode, and the MIX and SUM states. An empty sample and a
// hit at the table ends skip the scan. The next request is taken in the cycle
// after the result is registered; a finished result waits in an output
// register while the next request is taken.
module keyframe_curve_interpolator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic signed [31:0]            time_point_i,
  input  logic signed [31:0]            key_level_i,
  input  logic [1:0]                    blend_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            curve_value_o,
  output logic [2:0]                    status_o
);
  import kci_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               cmd_q, cmd_d;
  logic [DATA_W-1:0]  qt_q, qt_d;
  logic [DATA_W-1:0]  lv_q, lv_d;
  logic [1:0]         md_q, md_d;
  key_t               prev_q, prev_d;
  logic [DATA_W-1:0]  v1_q, v1_d;
  logic [WGT_W-1:0]   f_q, f_d;
  logic [WGT_W-1:0]   a_q, a_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0]  res_val_q, res_val_d;
  logic [2:0]         res_stat_q, res_stat_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  out_val_q, out_val_d;
  logic [2:0]         out_stat_q, out_stat_d;

  logic               ram_we;
  logic [KEY_AW-1:0]  ram_waddr, ram_raddr;
  key_t               ram_wdata, ram_rdata;

  logic               div_start, div_done;
  logic [DIFF_W-1:0]  div_num, div_den;
  logic [WGT_W-1:0]   div_quo;

  logic               in_acc;
  logic               out_free;
  logic [CNT_W-1:0]   last_idx;
  logic               q_le_rd, q_ge_rd, rd_lt_q, rd_eq_q;
  logic [SQ_W-1:0]    sq;
  logic [CUBE_W-1:0]  cube;
  logic [SM_W-1:0]    sm;
  logic signed [DIFF_W-1:0] dv;
  logic signed [PROD_W-1:0] shifted;

  kci_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_idx   = count_q - 1'b1;

  assign q_le_rd = $signed(qt_q) <= $signed(ram_rdata.time_pt);
  assign q_ge_rd = $signed(qt_q) >= $signed(ram_rdata.time_pt);
  assign rd_lt_q = $signed(ram_rdata.time_pt) < $signed(qt_q);
  assign rd_eq_q = ram_rdata.time_pt == qt_q;

  assign sq      = f_q * f_q;
  assign cube    = THREE_ONE - {1'b0, f_q, 1'b0};
  assign sm      = a_q * cube;
  assign dv      = $signed({v1_q[DATA_W-1], v1_q}) - $signed({prev_q.level[DATA_W-1],
                                                              prev_q.level});
  assign shifted = prod_q >>> FRAC_BITS;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_SAMPLE) begin
            state_d = (count_q == '0) ? S_DONE : S_S_FIRST;
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_A_RD:    state_d = (pos_q == count_q) ? S_A_PLACE : S_A_CMP;
      S_A_CMP: begin
        if (rd_lt_q) begin
          state_d = S_A_RD;
        end else if (rd_eq_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_A_PLACE;
        end
      end
      S_A_PLACE: state_d = (count_q == CNT_W'(MAX_KEYS)) ? S_DONE : S_SH_RD;
      S_SH_RD:   state_d = (idx_q == pos_q) ? S_DONE : S_SH_WR;
      S_SH_WR:   state_d = S_SH_RD;
      S_S_FIRST: state_d = q_le_rd ? S_DONE : S_S_LAST;
      S_S_LAST:  state_d = q_ge_rd ? S_DONE : S_S_SCAN;
      S_S_SCAN: begin
        if (q_le_rd) begin
          state_d = (prev_q.mode == MODE_STEP) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = (prev_q.mode == MODE_SMOOTH) ? S_SM1 : S_MIX;
        end
      end
      S_SM1:  state_d = S_SM2;
      S_SM2:  state_d = S_MIX;
      S_MIX:  state_d = S_SUM;
      S_SUM:  state_d = S_DONE;
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    qt_d        = qt_q;
    lv_d        = lv_q;
    md_d        = md_q;
    prev_d      = prev_q;
    v1_d        = v1_q;
    f_d         = f_q;
    a_d         = a_q;
    prod_d      = prod_q;
    res_val_d   = res_val_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_stat_d  = out_stat_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[KEY_AW-1:0];
    ram_wdata   = '{time_pt: qt_q, level: lv_q, mode: md_q};
    ram_raddr   = '0;
    div_start   = 1'b0;
    div_num     = DIFF_W'($signed(qt_q)) - DIFF_W'($signed(prev_q.time_pt));
    div_den     = DIFF_W'($signed(v1_q)) - DIFF_W'($signed(prev_q.time_pt));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d      = cmd_i;
          qt_d       = time_point_i;
          lv_d       = key_level_i;
          md_d       = blend_mode_i;
          pos_d      = '0;
          res_val_d  = '0;
          res_stat_d = STAT_EMPTY;
        end
      end
      S_A_RD: begin
        ram_raddr = pos_q[KEY_AW-1:0];
      end
      S_A_CMP: begin
        if (rd_lt_q) begin
          pos_d = pos_q + 1'b1;
        end else if (rd_eq_q) begin
          // keep the stored time, replace value and mode
          ram_we     = 1'b1;
          res_stat_d = STAT_UPDATED;
        end
      end
      S_A_PLACE: begin
        idx_d      = count_q;
        res_stat_d = STAT_DROPPED;
      end
      S_SH_RD: begin
        ram_raddr = idx_q[KEY_AW-1:0] - 1'b1;
        if (idx_q == pos_q) begin
          ram_we     = 1'b1;
          count_d    = count_q + 1'b1;
          res_stat_d = STAT_INSERTED;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[KEY_AW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_q - 1'b1;
      end
      S_S_FIRST: begin
        prev_d     = ram_rdata;
        ram_raddr  = last_idx[KEY_AW-1:0];
        res_stat_d = STAT_SAMPLED;
        res_val_d  = ram_rdata.level;
      end
      S_S_LAST: begin
        res_val_d = ram_rdata.level;
        idx_d     = CNT_W'(1);
        ram_raddr = KEY_AW'(1);
      end
      S_S_SCAN: begin
        if (q_le_rd) begin
          // latch the upper key level and, unless the lower key is a step key, start the weight division
          res_val_d = prev_q.level;
          v1_d      = ram_rdata.level;
          div_den   = DIFF_W'($signed(ram_rdata.time_pt)) -
                      DIFF_W'($signed(prev_q.time_pt));
          div_start = (prev_q.mode != MODE_STEP);
        end else begin
          prev_d    = ram_rdata;
          idx_d     = idx_q + 1'b1;
          ram_raddr = idx_q[KEY_AW-1:0] + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          f_d = div_quo;
        end
      end
      S_SM1: begin
        a_d = sq[FRAC_BITS +: WGT_W];
      end
      S_SM2: begin
        f_d = sm[FRAC_BITS +: WGT_W];
      end
      S_MIX: begin
        prod_d = PROD_W'(dv) * $signed({{(PROD_W-WGT_W){1'b0}}, f_q});
      end
      S_SUM: begin
        res_val_d = prev_q.level + shifted[DATA_W-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = (cmd_q == CMD_SAMPLE) ? res_val_q : '0;
          out_stat_d  = res_stat_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    qt_q       <= qt_d;
    lv_q       <= lv_d;
    md_q       <= md_d;
    prev_q     <= prev_d;
    v1_q       <= v1_d;
    f_q        <= f_d;
    a_q        <= a_d;
    prod_q     <= prod_d;
    res_val_q  <= res_val_d;
    res_stat_q <= res_stat_d;
    out_val_q  <= out_val_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o   = out_valid_q;
  assign curve_value_o = out_val_q;
  assign status_o      = out_stat_q;

endmodule
